[rtl/core/dlefrm_pkg.sv]
// Shared types, constants and codes of the DLE STX/ETX deframer.
package dlefrm_pkg;

    // Payload count at which a frame is aborted
    localparam int unsigned MAX_FRAME = 64;
    localparam int unsigned CNT_W     = $clog2(MAX_FRAME);

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned POS_W  = 7;
    localparam int unsigned IDX_W  = 2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ABORT   = 2'd2;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_START  = 2'd0;
    localparam logic [IDX_W-1:0] REG_END    = 2'd1;
    localparam logic [IDX_W-1:0] REG_ESCAPE = 2'd2;

    // Register reset values
    localparam logic [BYTE_W-1:0] START_RST  = 8'd36;
    localparam logic [BYTE_W-1:0] END_RST    = 8'd13;
    localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'd16;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] end_byte;
        logic [BYTE_W-1:0] escape_byte;
    } dlefrm_cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [POS_W-1:0]  position;
    } dlefrm_res_t;

endpackage

[rtl/core/dlefrm_cfg.sv]
// Configuration registers: start, end and escape byte values.
module dlefrm_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [dlefrm_pkg::IDX_W-1:0]  cfg_index,
    input  logic [dlefrm_pkg::BYTE_W-1:0] cfg_data,
    output dlefrm_pkg::dlefrm_cfg_t     cfg
);
    import dlefrm_pkg::*;

    dlefrm_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_byte  <= START_RST;
            cfg_reg.end_byte    <= END_RST;
            cfg_reg.escape_byte <= ESCAPE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_START:  cfg_reg.start_byte  <= cfg_data;
                REG_END:    cfg_reg.end_byte    <= cfg_data;
                REG_ESCAPE: cfg_reg.escape_byte <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/dlefrm_core.sv]
// Frame state (in-frame, escape, count) and per-byte decode.
module dlefrm_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic [dlefrm_pkg::BYTE_W-1:0] rx_byte,
    input  dlefrm_pkg::dlefrm_cfg_t       cfg,
    output logic                          res_valid,
    output dlefrm_pkg::dlefrm_res_t       res
);
    import dlefrm_pkg::*;

    logic             in_frame_reg, in_frame_next;
    logic             esc_reg, esc_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W:0]   count_inc;
    logic             take;
    logic             hit;

    assign count_inc = {1'b0, count_reg} + 1'b1;

    always_comb begin
        in_frame_next = in_frame_reg;
        esc_next      = esc_reg;
        count_next    = count_reg;
        take          = 1'b0;
        hit           = 1'b0;
        res           = '0;

        if (esc_reg && in_frame_reg) begin
            esc_next = 1'b0;
            take     = 1'b1;
        end else if (rx_byte == cfg.escape_byte) begin
            // Escape stays pending even outside a frame
            esc_next = 1'b1;
        end else if (rx_byte == cfg.start_byte) begin
            in_frame_next = 1'b1;
            count_next    = '0;
        end else if (rx_byte == cfg.end_byte) begin
            if (in_frame_reg) begin
                in_frame_next    = 1'b0;
                hit              = 1'b1;
                res.kind         = KIND_DONE;
                res.position     = POS_W'(count_reg);
            end
        end else if (in_frame_reg) begin
            take = 1'b1;
        end

        if (take) begin
            hit              = 1'b1;
            res.payload_byte = rx_byte;
            if (count_inc >= (CNT_W+1)'(MAX_FRAME)) begin
                // Overflow: drop the frame
                in_frame_next = 1'b0;
                esc_next      = 1'b0;
                count_next    = '0;
                res.kind      = KIND_ABORT;
                res.position  = POS_W'(MAX_FRAME);
            end else begin
                count_next    = count_inc[CNT_W-1:0];
                res.kind      = KIND_PAYLOAD;
                res.position  = POS_W'(count_reg);
            end
        end
    end

    assign res_valid = accept && hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            esc_reg      <= 1'b0;
            count_reg    <= '0;
        end else if (accept) begin
            in_frame_reg <= in_frame_next;
            esc_reg      <= esc_next;
            count_reg    <= count_next;
        end
    end

    a_abort_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.kind == KIND_ABORT |=> !in_frame_reg && !esc_reg && count_reg == '0)
        else $error("abort did not clear frame state");

    a_payload_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.kind == KIND_PAYLOAD |=> count_reg == $past(count_reg) + 1'b1)
        else $error("payload beat did not advance the count");

    a_result_needs_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> in_frame_reg)
        else $error("result produced outside a frame");

endmodule

[rtl/core/dlefrm_skid.sv]
// Result register with a skid stage so input ready never waits on m_ready.
module dlefrm_skid (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    res_valid,
    input  dlefrm_pkg::dlefrm_res_t res,
    output logic                    in_ready,
    output logic                    m_valid,
    input  logic                    m_ready,
    output dlefrm_pkg::dlefrm_res_t m_res
);
    import dlefrm_pkg::*;

    logic        out_valid_reg;
    logic        skid_valid_reg;
    dlefrm_res_t out_reg;
    dlefrm_res_t skid_reg;
    logic        out_fire;

    assign out_fire = out_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_fire) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (res_valid) begin
            if (!out_valid_reg || out_fire) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (out_fire) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_fire) begin
                out_reg <= skid_reg;
            end
        end else if (res_valid) begin
            if (!out_valid_reg || out_fire) begin
                out_reg <= res;
            end else begin
                skid_reg <= res;
            end
        end
    end

    assign in_ready = !skid_valid_reg;
    assign m_valid  = out_valid_reg;
    assign m_res    = out_reg;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while output is empty");

    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !m_ready |=> skid_valid_reg && $stable(skid_reg))
        else $error("skid beat lost under stall");

    a_skid_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && m_ready |=> out_valid_reg && out_reg == $past(skid_reg))
        else $error("skid beat not advanced to output");

endmodule

[rtl/core/dle_stx_etx_deframer.sv]
// Top level of the DLE byte-stuffed STX/ETX deframer.
//
// Input channel s_*: one received byte per beat (s_rx_byte). A start byte
// opens or restarts a frame, an escape byte makes the next byte literal,
// and an end byte closes the frame. Output channel m_*: zero or one result
// beat per input byte: kind payload (byte and its index in the frame),
// kind done (frame length in m_position) or kind abort (frame reached
// MAX_FRAME payload bytes; the offending byte rides along).
// Throughput: one byte per cycle while s_ready is high. A result is
// decoded combinationally from its byte and the frame state by the single
// decode stage, and registered in the result register.
// When the receiver stalls, the result register holds its beat and one
// more result lands in the skid stage; s_ready drops only while the skid
// stage is full, and comes straight from a flop.
// Reset (aresetn, synchronous, active low) closes any frame, clears the
// escape flag and count, empties both output stages and restores the
// start/end/escape registers to 36, 13 and 16. Write cfg_* only while idle.
module dle_stx_etx_deframer (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic [dlefrm_pkg::IDX_W-1:0]       cfg_index,
    input  logic [dlefrm_pkg::BYTE_W-1:0]      cfg_data,
    // received bytes
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [dlefrm_pkg::BYTE_W-1:0]      s_rx_byte,
    // decoded results
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [dlefrm_pkg::KIND_W-1:0]      m_kind,
    output logic [dlefrm_pkg::BYTE_W-1:0]      m_payload_byte,
    output logic [dlefrm_pkg::POS_W-1:0]       m_position
);
    import dlefrm_pkg::*;

    dlefrm_cfg_t cfg;
    dlefrm_res_t res;
    dlefrm_res_t m_res;
    logic        res_valid;
    logic        in_ready;
    logic        accept;

    assign s_ready = in_ready;
    assign accept  = s_valid && in_ready;

    // Hold the three control byte values
    dlefrm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Decode the byte and advance frame state on each accepted beat
    dlefrm_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .rx_byte   (s_rx_byte),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Register results; absorb one extra beat while the receiver stalls
    dlefrm_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .in_ready  (in_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_kind         = m_res.kind;
    assign m_payload_byte = m_res.payload_byte;
    assign m_position     = m_res.position;

endmodule

[bench/dle_stx_etx_deframer_tb.sv]
// Self-checking testbench for the DLE byte-stuffed STX/ETX deframer.
module dle_stx_etx_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dlefrm_pkg::*;

    // Cycles without any beat on either channel before the run is declared hung
    localparam int unsigned STALL_LIMIT = 5000;
    // Cycles to let the result stage settle after the last expected result
    localparam int unsigned TAIL_CYCLES = 4;

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               cfg_wr_en      = 1'b0;
    logic [IDX_W-1:0]   cfg_index      = '0;
    logic [BYTE_W-1:0]  cfg_data       = '0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic [BYTE_W-1:0]  s_rx_byte      = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic [KIND_W-1:0]  m_kind;
    logic [BYTE_W-1:0]  m_payload_byte;
    logic [POS_W-1:0]   m_position;

    dle_stx_etx_deframer i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_payload_byte (m_payload_byte),
        .m_position     (m_position)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Framing codes as the deframer should currently see them
    logic [BYTE_W-1:0] code_start  = START_RST;
    logic [BYTE_W-1:0] code_end    = END_RST;
    logic [BYTE_W-1:0] code_escape = ESCAPE_RST;

    // Shadow frame state
    bit          fr_open    = 1'b0;
    bit          fr_escaped = 1'b0;
    int unsigned fr_count   = 0;

    // Decoded results still owed by the block, oldest first
    dlefrm_res_t decoded_q[$];
    dlefrm_res_t decoded_head;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned err_count     = 0;
    int unsigned n_bytes       = 0;
    int unsigned n_payload     = 0;
    int unsigned n_done        = 0;
    int unsigned n_abort       = 0;
    int unsigned stall_cycles  = 0;

    // Take one payload byte into the open frame; abort when the frame is full.
    function automatic bit frame_take(input logic [BYTE_W-1:0] b, output dlefrm_res_t r);
        r = '0;
        r.payload_byte = b;
        if (fr_count + 1 >= MAX_FRAME) begin
            fr_open    = 1'b0;
            fr_escaped = 1'b0;
            fr_count   = 0;
            r.kind     = KIND_ABORT;
            r.position = POS_W'(MAX_FRAME);
        end else begin
            r.kind     = KIND_PAYLOAD;
            r.position = POS_W'(fr_count);
            fr_count++;
        end
        return 1'b1;
    endfunction

    // Advance the shadow state by one received byte; return 1 if a result is due.
    function automatic bit frame_predict(input logic [BYTE_W-1:0] b, output dlefrm_res_t r);
        r = '0;
        // a pending escape only takes effect once a frame is open
        if (fr_escaped && fr_open) begin
            fr_escaped = 1'b0;
            return frame_take(b, r);
        end
        // codes are matched escape first, then start, then end
        if (b == code_escape) begin
            fr_escaped = 1'b1;
            return 1'b0;
        end
        if (b == code_start) begin
            fr_count = 0;
            fr_open  = 1'b1;
            return 1'b0;
        end
        if (b == code_end) begin
            if (!fr_open)
                return 1'b0;
            fr_open    = 1'b0;
            r.kind     = KIND_DONE;
            r.position = POS_W'(fr_count);
            return 1'b1;
        end
        if (fr_open)
            return frame_take(b, r);
        return 1'b0;
    endfunction

    // Send one received byte as a beat; hold it until taken, then predict.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        dlefrm_res_t r;
        // random gap: drop valid for the idle cycles
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        if (frame_predict(b, r))
            decoded_q.push_back(r);
        n_bytes++;
    endtask

    // Drop valid, wait for every owed result, then let the pipeline settle.
    task automatic wait_drain();
        s_valid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // Write one register; the block must be idle.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_START:  code_start  = val;
            REG_END:    code_end    = val;
            REG_ESCAPE: code_escape = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_codes(input logic [BYTE_W-1:0] st, input logic [BYTE_W-1:0] en,
                             input logic [BYTE_W-1:0] es);
        wait_drain();
        write_reg(REG_START, st);
        write_reg(REG_END, en);
        write_reg(REG_ESCAPE, es);
    endtask

    // Payload byte biased toward the framing codes, so escaping gets exercised
    function automatic logic [BYTE_W-1:0] pick_payload();
        case ($urandom_range(7))
            0:       return code_start;
            1:       return code_end;
            2:       return code_escape;
            default: return BYTE_W'($urandom_range(255));
        endcase
    endfunction

    // Well-formed frame: start, stuffed payload, and an end code if closed
    task automatic send_frame(input int unsigned len, input bit closed);
        logic [BYTE_W-1:0] b;
        send_byte(code_start);
        for (int unsigned i = 0; i < len; i++) begin
            b = pick_payload();
            // escape every code value, and now and then a plain byte too
            if (b == code_start || b == code_end || b == code_escape ||
                $urandom_range(9) == 0)
                send_byte(code_escape);
            send_byte(b);
        end
        if (closed)
            send_byte(code_end);
    endtask

    // ---------------------------------------------------------------- tests

    // Plain frame with the byte extremes as payload
    task automatic test_basic_frame();
        send_byte(code_start);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(code_end);
    endtask

    // Stray end and noise outside a frame are dropped; empty frame gives length 0
    task automatic test_empty_and_stray();
        send_byte(code_end);
        send_byte(8'hAA);
        send_byte(code_start);
        send_byte(code_end);
    endtask

    // Escaped start, end and escape codes ride through as payload
    task automatic test_escaped_codes();
        send_byte(code_start);
        send_byte(code_escape);
        send_byte(code_start);
        send_byte(code_escape);
        send_byte(code_end);
        send_byte(code_escape);
        send_byte(code_escape);
        send_byte(code_end);
    endtask

    // Escape outside a frame stays pending and makes the first frame byte literal
    task automatic test_escape_outside();
        send_byte(code_escape);
        send_byte(8'h55);
        send_byte(code_start);
        send_byte(code_start);
        send_byte(code_end);
    endtask

    // Start equal to end: start wins, so the frame restarts instead of closing
    task automatic test_code_collision();
        set_codes(8'd7, 8'd7, 8'd9);
        send_byte(8'd7);
        send_byte(8'd1);
        send_byte(8'd7);
        send_byte(8'd2);
        send_byte(8'd9);
        send_byte(8'd7);
    endtask

    // Mostly well-formed frames, plus open frames and noise, until the byte target
    task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct,
                                       input logic [BYTE_W-1:0] st,
                                       input logic [BYTE_W-1:0] en,
                                       input logic [BYTE_W-1:0] es,
                                       input int unsigned long_len,
                                       input int unsigned n_target);
        int unsigned target;
        int unsigned pick;
        int unsigned len;
        set_codes(st, en, es);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        target = n_bytes + n_target;
        // one long frame per phase to reach the full-frame boundary
        send_frame(long_len, 1'b1);
        while (n_bytes < target) begin
            pick = $urandom_range(99);
            len  = ($urandom_range(99) < 92) ? $urandom_range(8) : $urandom_range(70, 9);
            if (pick < 70) begin
                send_frame(len, 1'b1);
            end else if (pick < 80) begin
                send_frame(len, 1'b0);
            end else if (pick < 88) begin
                send_byte(code_escape);
            end else if (pick < 93) begin
                send_byte(code_end);
            end else begin
                send_byte(BYTE_W'($urandom_range(255)));
            end
        end
    endtask

    // ------------------------------------------------------- result checker

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (decoded_q.size() == 0) begin
                $error("unexpected result beat: kind %0d byte %0h position %0d",
                       m_kind, m_payload_byte, m_position);
                err_count++;
            end else begin
                decoded_head = decoded_q.pop_front();
                if (m_kind !== decoded_head.kind) begin
                    $error("kind: expected %0d, actual %0d", decoded_head.kind, m_kind);
                    err_count++;
                end
                if (m_payload_byte !== decoded_head.payload_byte) begin
                    $error("payload_byte: expected %0h, actual %0h",
                           decoded_head.payload_byte, m_payload_byte);
                    err_count++;
                end
                if (m_position !== decoded_head.position) begin
                    $error("position: expected %0d, actual %0d",
                           decoded_head.position, m_position);
                    err_count++;
                end
                case (decoded_head.kind)
                    KIND_PAYLOAD: n_payload++;
                    KIND_DONE:    n_done++;
                    default:      n_abort++;
                endcase
            end
        end
    end

    // Receiver back-pressure
    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Watchdog: any beat on either side resets the stall count
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------- sequence

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed checks, mostly at the reset codes, light sender gaps, heavy stalls
        send_idle_pct = 9;
        recv_idle_pct = 59;
        test_basic_frame();
        test_empty_and_stray();
        test_escaped_codes();
        test_escape_outside();
        test_code_collision();

        // random traffic: code extremes, and the three idling mixes in turn
        test_random_traffic(9, 59, 8'd0, 8'd255, 8'd16, 63, 130);
        test_random_traffic(59, 9, 8'd255, 8'd128, 8'd0, 64, 130);
        wait_drain();
        // write to the unused index; it must change nothing
        write_reg(IDX_W'(3), BYTE_W'($urandom_range(255)));
        test_random_traffic(0, 0, 8'd2, 8'd3, 8'd255, 70, 130);

        wait_drain();
        $display("Sent %0d bytes over reset, extreme and colliding framing codes.", n_bytes);
        $display("Checked %0d payload, %0d complete and %0d aborted results.",
                 n_payload, n_done, n_abort);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/core/dlefrm_pkg.sv
rtl/core/dlefrm_cfg.sv
rtl/core/dlefrm_core.sv
rtl/core/dlefrm_skid.sv
rtl/core/dle_stx_etx_deframer.sv
bench/dle_stx_etx_deframer_tb.sv
